FILE: rtl/core/wchn_pkg.sv
// Shared constants, types and helpers of the wall curvature pipeline.
package wchn_pkg;

  localparam int FRAC_BITS = 16;

  localparam int HW     = 32;             // height width
  localparam int SW     = 31;             // spacing width
  localparam int SINE_W = 18;             // contact angle sine register width
  localparam int DW     = HW + 1;         // height difference width
  localparam int NRM_W  = 31;             // normalized operand width
  localparam int RT_W   = 32;             // root width
  localparam int MAGW   = FRAC_BITS + 1;  // side normal magnitude width
  localparam int SIDE_LAT = 4 + RT_W + 1 + MAGW;

  localparam int NV_W = FRAC_BITS + 3;    // signed side normal
  localparam int DF_W = FRAC_BITS + 4;    // signed normal difference
  localparam int QW   = 33;               // curvature quotient bits
  localparam int NUMW = (((2 * FRAC_BITS + 3) > 30) ? (2 * FRAC_BITS + 3) : 30) + 1;
  localparam int NUMP = (NUMW > QW) ? NUMW : QW + 1;

  localparam int SH_L = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_R = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  localparam logic [HW-1:0] CURV_MAX = {1'b0, {(HW-1){1'b1}}};
  localparam logic [HW-1:0] CURV_MIN = {1'b1, {(HW-1){1'b0}}};

  // per-item sideband that rides next to the two side lanes
  typedef struct packed {
    logic          wall_m;
    logic          wall_p;
    logic          neg;
    logic [SW-1:0] dc;
  } sband_t;

  // control carried through the curvature divider
  typedef struct packed {
    logic          big;
    logic          sgn;
    logic          zero;
    logic [SW-1:0] dc;
  } dctl_t;

  // sine register (16 fraction bits) to FRAC_BITS, floor on right shift
  function automatic logic signed [NV_W-1:0] sine_fix(input logic signed [SINE_W-1:0] c);
    logic signed [63:0] w;
    w = {{(64-SINE_W){c[SINE_W-1]}}, c};
    if (FRAC_BITS >= 16) w = w <<< SH_L;
    else                 w = w >>> SH_R;
    return w[NV_W-1:0];
  endfunction

endpackage

FILE: rtl/core/wchn_in_if.sv
// Input channel: heights, spacings and phase sign of one cell.
interface wchn_in_if import wchn_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [HW-1:0] height_minus;
  logic signed [HW-1:0] height_centre;
  logic signed [HW-1:0] height_plus;
  logic [SW-1:0]        spacing_minus;
  logic [SW-1:0]        spacing_centre;
  logic [SW-1:0]        spacing_plus;
  logic                 phase_negative;

  modport source(output valid, height_minus, height_centre, height_plus, spacing_minus,
                 spacing_centre, spacing_plus, phase_negative, input ready);
  modport sink(input valid, height_minus, height_centre, height_plus, spacing_minus,
               spacing_centre, spacing_plus, phase_negative, output ready);
endinterface

FILE: rtl/core/wchn_out_if.sv
// Result channel: curvature and saturation flag.
interface wchn_out_if import wchn_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [HW-1:0] curvature;
  logic                 overflow;

  modport source(output valid, curvature, overflow, input ready);
  modport sink(input valid, curvature, overflow, output ready);
endinterface

FILE: rtl/core/wchn_side.sv
// One side lane: normal magnitude |d|/sqrt(d^2+s^2) as a bit-per-stage pipeline.
module wchn_side import wchn_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [DW-1:0] d_i,
  input  logic [SW-1:0]        s_i,
  output logic [MAGW-1:0]      mag_o,
  output logic                 neg_o
);

  localparam int NUM1 = NRM_W + FRAC_BITS + 1;

  typedef struct packed {
    logic             za;
    logic             zb;
    logic             sg;
    logic [NRM_W-1:0] a;
  } sctl_t;

  // stage A: magnitude and leading one
  logic [HW-1:0] ad;
  logic [HW-1:0] orv;
  logic [5:0]    bl;
  logic [HW-1:0] a_r;
  logic [SW-1:0] b_r;
  logic          za_r, zb_r, sg_r;
  logic [5:0]    bl_r;

  always_comb begin
    logic [DW-1:0] t;
    t   = d_i[DW-1] ? DW'(-d_i) : DW'(d_i);
    ad  = t[HW-1:0];
    orv = ad | {1'b0, s_i};
    bl  = '0;
    for (int i = 0; i < HW; i++) begin
      if (orv[i]) bl = 6'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= ad;
      b_r  <= s_i;
      za_r <= (ad == '0);
      zb_r <= (s_i == '0);
      sg_r <= d_i[DW-1];
      bl_r <= bl;
    end
  end

  // stage B: scale so the larger operand lies in [2^30, 2^31)
  logic [5:0]       sh;
  logic [NRM_W-1:0] an, bn;
  logic [NRM_W-1:0] an_r, bn_r;
  sctl_t            cb_r;

  always_comb begin
    logic [HW-1:0] ta, tb;
    sh = 6'd31 - bl_r;
    if (bl_r == 6'd32) begin
      ta = a_r >> 1;
      tb = {1'b0, b_r} >> 1;
    end else begin
      ta = a_r << sh;
      tb = {1'b0, b_r} << sh;
    end
    an = ta[NRM_W-1:0];
    bn = tb[NRM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      an_r <= an;
      bn_r <= bn;
      cb_r <= '{za: za_r, zb: zb_r, sg: sg_r, a: an};
    end
  end

  // stage C: squares
  logic [2*NRM_W-1:0] aa_r, bb_r;
  sctl_t              cc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      aa_r <= (2*NRM_W)'(an_r) * (2*NRM_W)'(an_r);
      bb_r <= (2*NRM_W)'(bn_r) * (2*NRM_W)'(bn_r);
      cc_r <= cb_r;
    end
  end

  // stage D (root stage 0): sum of squares; then one root bit a stage
  logic [63:0]     vv_r [0:RT_W];
  logic [RT_W-1:0] rt_r [0:RT_W];
  logic [34:0]     rm_r [0:RT_W];
  sctl_t           cs_r [0:RT_W];

  always_ff @(posedge clk) begin
    if (en) begin
      vv_r[0] <= 64'(aa_r) + 64'(bb_r);
      rt_r[0] <= '0;
      rm_r[0] <= '0;
      cs_r[0] <= cc_r;
    end
  end

  for (genvar k = 0; k < RT_W; k++) begin : g_sqrt
    logic [34:0] rs, tr;
    logic        ge;
    assign rs = {rm_r[k][32:0], vv_r[k][63:62]};
    assign tr = {1'b0, rt_r[k], 2'b01};
    assign ge = (rs >= tr);
    always_ff @(posedge clk) begin
      if (en) begin
        vv_r[k+1] <= vv_r[k] << 2;
        rm_r[k+1] <= ge ? rs - tr : rs;
        rt_r[k+1] <= {rt_r[k][RT_W-2:0], ge};
        cs_r[k+1] <= cs_r[k];
      end
    end
  end

  // divider: (a*2^F + r/2) / r, quotient fits MAGW bits
  logic [NUM1-1:0] num;
  logic [RT_W-1:0] rd_r [0:MAGW];
  logic [MAGW-1:0] nn_r [0:MAGW];
  logic [MAGW-1:0] qq_r [0:MAGW];
  logic [RT_W-1:0] rr_r [0:MAGW];
  sctl_t           cd_r [0:MAGW];

  assign num = {cs_r[RT_W].a, {FRAC_BITS{1'b0}}} + NUM1'(rt_r[RT_W] >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      rd_r[0] <= RT_W'(num[NUM1-1:MAGW]);
      nn_r[0] <= num[MAGW-1:0];
      qq_r[0] <= '0;
      rr_r[0] <= rt_r[RT_W];
      cd_r[0] <= cs_r[RT_W];
    end
  end

  for (genvar j = 0; j < MAGW; j++) begin : g_div
    logic [RT_W:0] t;
    logic          ge;
    assign t  = {rd_r[j], nn_r[j][MAGW-1]};
    assign ge = (t >= {1'b0, rr_r[j]});
    always_ff @(posedge clk) begin
      if (en) begin
        rd_r[j+1] <= ge ? RT_W'(t - {1'b0, rr_r[j]}) : t[RT_W-1:0];
        nn_r[j+1] <= nn_r[j] << 1;
        qq_r[j+1] <= {qq_r[j][MAGW-2:0], ge};
        rr_r[j+1] <= rr_r[j];
        cd_r[j+1] <= cd_r[j];
      end
    end
  end

  always_comb begin
    if (cd_r[MAGW].za)      mag_o = '0;
    else if (cd_r[MAGW].zb) mag_o = MAGW'(1) << FRAC_BITS;
    else                    mag_o = qq_r[MAGW];
    neg_o = cd_r[MAGW].sg;
  end

endmodule

FILE: rtl/core/wall_curvature_height_normal_2d_top.sv
// Top level of the wall curvature pipeline.
//
// Usage:
//   in_ch  : one word per interface cell: three heights, three spacings and
//            the phase sign (valid/ready, taken when both are high).
//   out_ch : one word per input word, in order: curvature and overflow.
//   cfg_we/cfg_wdata : contact angle sine, Q2.16, 18 bits signed. Write it
//            only while nothing is in flight; it is read at E1, after the
//            side lanes.
// Throughput: one word per cycle while the receiver takes the output.
// Depth: SIDE_LAT + QW + 5 register stages (92 at 16 fraction bits), set by
//   the 32-stage square root and the two long dividers, one quotient bit per
//   stage.
// The whole pipe moves as one: it advances whenever the output register is
// empty or being taken. When the receiver stalls with a word waiting,
// every stage holds, in_ch.ready drops, and nothing is lost or repeated.
// Bubbles travel as cleared valid bits, so partial fills drain normally.
// Reset (rst_n low, synchronous) clears all valid bits and the sine
// register; no word comes out until one has been accepted.
module wall_curvature_height_normal_2d_top import wchn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  wchn_in_if.sink           in_ch,
  wchn_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [SINE_W-1:0] cfg_wdata
);

  localparam int NST = SIDE_LAT + 5 + QW;   // register stages incl. output
  localparam int E1  = SIDE_LAT + 1;

  logic                     adv;
  logic [NST-1:0]           vld_r;
  logic signed [SINE_W-1:0] sine_r;

  assign adv         = !vld_r[NST-1] || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      sine_r <= '0;
    end else begin
      if (adv) vld_r <= {vld_r[NST-2:0], in_ch.valid};
      if (cfg_we) sine_r <= cfg_wdata;
    end
  end

  // stage 0: input register
  logic signed [HW-1:0] hm_r, hc_r, hp_r;
  logic [SW-1:0]        dm_r, dp_r;
  sband_t               sb_r [0:SIDE_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      hm_r     <= in_ch.height_minus;
      hc_r     <= in_ch.height_centre;
      hp_r     <= in_ch.height_plus;
      dm_r     <= in_ch.spacing_minus;
      dp_r     <= in_ch.spacing_plus;
      sb_r[0]  <= '{wall_m: (in_ch.height_minus <= 0),
                    wall_p: (in_ch.height_plus <= 0),
                    neg:    in_ch.phase_negative,
                    dc:     in_ch.spacing_centre};
    end
  end

  for (genvar k = 0; k < SIDE_LAT; k++) begin : g_sb
    always_ff @(posedge clk) begin
      if (adv) sb_r[k+1] <= sb_r[k];
    end
  end

  // side lanes
  logic signed [DW-1:0] d_m, d_p;
  logic [MAGW-1:0]      mag_m, mag_p;
  logic                 sg_m, sg_p;

  assign d_m = DW'(hc_r) - DW'(hm_r);
  assign d_p = DW'(hp_r) - DW'(hc_r);

  wchn_side u_side_m (.clk(clk), .en(adv), .d_i(d_m), .s_i(dm_r), .mag_o(mag_m), .neg_o(sg_m));
  wchn_side u_side_p (.clk(clk), .en(adv), .d_i(d_p), .s_i(dp_r), .mag_o(mag_p), .neg_o(sg_p));

  // E1: side normals, wall sides take the contact angle sine
  logic signed [NV_W-1:0] c_fix, sm, sp, nm_nxt, np_nxt;
  logic signed [NV_W-1:0] nm_r, np_r;
  sband_t                 sb_last;
  logic [SW-1:0]          dc_e1_r;

  assign sb_last = sb_r[SIDE_LAT];
  assign c_fix   = sine_fix(sine_r);

  always_comb begin
    // normal is negative when the difference sign matches the phase flag
    sm = (sg_m == sb_last.neg) ? -NV_W'(mag_m) : NV_W'(mag_m);
    sp = (sg_p == sb_last.neg) ? -NV_W'(mag_p) : NV_W'(mag_p);
    nm_nxt = sb_last.wall_m ? (sb_last.neg ? c_fix : -c_fix) : sm;
    np_nxt = sb_last.wall_p ? (sb_last.neg ? -c_fix : c_fix) : sp;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nm_r    <= nm_nxt;
      np_r    <= np_nxt;
      dc_e1_r <= sb_last.dc;
    end
  end

  // E2: difference and its magnitude
  logic signed [DF_W-1:0] diff;
  logic [DF_W-1:0]        dmag_r;
  logic                   dsg_r, dz_r;
  logic [SW-1:0]          dc_e2_r;

  assign diff = DF_W'(np_r) - DF_W'(nm_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      dmag_r  <= diff[DF_W-1] ? DF_W'(-diff) : DF_W'(diff);
      dsg_r   <= diff[DF_W-1];
      dz_r    <= (diff == '0);
      dc_e2_r <= dc_e1_r;
    end
  end

  // E3: numerator, range check, divider seed
  logic [NUMP-1:0]    num;
  logic [NUMP-QW-1:0] rem0;
  logic [SW-1:0]      rd_r [0:QW];
  logic [QW-1:0]      nn_r [0:QW];
  logic [QW-1:0]      qq_r [0:QW];
  dctl_t              dv_r [0:QW];

  assign num  = (NUMP'(dmag_r) << FRAC_BITS) + NUMP'(dc_e2_r >> 1);
  assign rem0 = num[NUMP-1:QW];

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r[0] <= SW'(rem0);
      nn_r[0] <= num[QW-1:0];
      qq_r[0] <= '0;
      // quotient of 2^QW or more, or a zero divisor, saturates
      dv_r[0] <= '{big: (NUMP'(rem0) >= NUMP'(dc_e2_r)), sgn: dsg_r, zero: dz_r,
                   dc: dc_e2_r};
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [SW:0] t;
    logic        ge;
    assign t  = {rd_r[j], nn_r[j][QW-1]};
    assign ge = (t >= {1'b0, dv_r[j].dc});
    always_ff @(posedge clk) begin
      if (adv) begin
        rd_r[j+1] <= ge ? SW'(t - {1'b0, dv_r[j].dc}) : t[SW-1:0];
        nn_r[j+1] <= nn_r[j] << 1;
        qq_r[j+1] <= {qq_r[j][QW-2:0], ge};
        dv_r[j+1] <= dv_r[j];
      end
    end
  end

  // output stage: sign and saturation
  logic [HW-1:0] curv_nxt, curv_r;
  logic          ovf_nxt, ovf_r;
  dctl_t         dl;
  logic [QW-1:0] q;

  assign dl = dv_r[QW];
  assign q  = qq_r[QW];

  always_comb begin
    curv_nxt = '0;
    ovf_nxt  = 1'b0;
    if (!dl.zero) begin
      if (!dl.sgn) begin
        if (dl.big || q > QW'(CURV_MAX)) begin
          curv_nxt = CURV_MAX;
          ovf_nxt  = 1'b1;
        end else begin
          curv_nxt = q[HW-1:0];
        end
      end else begin
        if (dl.big || q > QW'(CURV_MIN)) begin
          curv_nxt = CURV_MIN;
          ovf_nxt  = 1'b1;
        end else begin
          curv_nxt = HW'(-q);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      curv_r <= curv_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  assign out_ch.curvature = curv_r;
  assign out_ch.overflow  = ovf_r;

  a_ovf_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.overflow) |->
      (out_ch.curvature == CURV_MAX || out_ch.curvature == CURV_MIN))
    else $error("overflow flagged on unsaturated curvature");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vld_r[0])
    else $error("accepted word did not enter the pipe");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipe moved during a stall");

  a_e1_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_r[E1-1]) |=> vld_r[E1])
    else $error("word lost leaving the side lanes");

endmodule
